[rtl/core/mxt_pkg.sv]
// Package for the max-XOR trie: sizes, request and status codes, item and node types.
`default_nettype none
package mxt_pkg;

    localparam int KEY_W      = 31;
    localparam int KEY_BITS   = 31;
    localparam int NODE_COUNT = 8192;
    localparam int COUNT_BITS = 16;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int FREE_BITS  = NODE_BITS + 1;
    localparam int LVL_BITS   = $clog2(KEY_BITS);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req_code;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] max_xor;
        logic [KEY_W-1:0] partner;
        logic [1:0]       status;
    } t_out_item;

    typedef struct packed {
        logic [NODE_BITS-1:0]  zero_link;
        logic [NODE_BITS-1:0]  one_link;
        logic [COUNT_BITS-1:0] zero_count;
        logic [COUNT_BITS-1:0] one_count;
    } t_node;

endpackage
`default_nettype wire

[rtl/core/mxt_node_ram.sv]
// Trie node memory: one write port and one registered read port.
`default_nettype none
module mxt_node_ram
    import mxt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic [NODE_BITS-1:0] i_rd_addr,
    output t_node                     o_rd_data,
    input  wire logic                 i_wr_en,
    input  wire logic [NODE_BITS-1:0] i_wr_addr,
    input  wire t_node                i_wr_data
);

    t_node r_mem [NODE_COUNT];

    // Read before write: the read data is registered and appears in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

[rtl/core/multiset_max_xor_trie_core.sv]
// Max-XOR binary trie over a multiset of keys, held in one node memory.
// After reset a clearing pass over all NODE_COUNT (8192) nodes loads the initial trie; no item is taken.
// A query reads one node per level; an unknown request goes straight to the result.
// Insert and remove walk the trie twice, check then update.
// One item is in work at a time; the result is held in an output register until taken.
`default_nettype none
module multiset_max_xor_trie_core
    import mxt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_in,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_out
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_HOLD
    } t_state;

    localparam logic [COUNT_BITS-1:0] CMAX    = '1;
    localparam logic [LVL_BITS-1:0]   LVL_TOP = LVL_BITS'(KEY_BITS - 1);

    t_state                r_state, n_state;
    logic [NODE_BITS-1:0]  r_clr, n_clr;
    logic [1:0]            r_req, n_req;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [KEY_W-1:0]      r_p, n_p;
    logic [LVL_BITS-1:0]   r_lvl, n_lvl;
    logic                  r_pass2, n_pass2;
    logic [NODE_BITS-1:0]  r_node, n_node;
    logic [FREE_BITS-1:0]  r_free, n_free;
    t_out_item             r_res, n_res;
    logic                  r_ov, n_ov;
    t_out_item             r_out, n_out;

    logic [NODE_BITS-1:0]  rd_addr;
    t_node                 rd_data;
    logic                  wr_en;
    logic [NODE_BITS-1:0]  wr_addr;
    t_node                 wr_data;

    logic                  b;
    logic                  want;
    logic                  take;
    logic [NODE_BITS-1:0]  link_b;
    logic [COUNT_BITS-1:0] cnt_b;
    logic [NODE_BITS-1:0]  link_w;
    logic [COUNT_BITS-1:0] cnt_w;
    logic [NODE_BITS-1:0]  nx;
    logic [NODE_BITS-1:0]  new_link;
    logic [FREE_BITS:0]    need_end;

    mxt_node_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Fields of the node now read, for this level's key bit.
    always_comb begin
        b        = r_key[r_lvl];
        want     = ~b;
        link_b   = b ? rd_data.one_link  : rd_data.zero_link;
        cnt_b    = b ? rd_data.one_count : rd_data.zero_count;
        link_w   = want ? rd_data.one_link  : rd_data.zero_link;
        cnt_w    = want ? rd_data.one_count : rd_data.zero_count;
        take     = (link_w != '0 && cnt_w != '0) ? want : b;
        nx       = take ? rd_data.one_link : rd_data.zero_link;
        new_link = (link_b == '0) ? r_free[NODE_BITS-1:0] : link_b;
        need_end = {1'b0, r_free} + (FREE_BITS + 1)'(r_lvl) + (FREE_BITS + 1)'(1);
    end

    // Sequencer: clearing pass, trie walks and result hand-off.
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_req   = r_req;
        n_key   = r_key;
        n_p     = r_p;
        n_lvl   = r_lvl;
        n_pass2 = r_pass2;
        n_node  = r_node;
        n_free  = r_free;
        n_res   = r_res;
        n_ov    = r_ov;
        n_out   = r_out;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_node;
        wr_data = rd_data;

        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // Initial trie: a zero-branch chain from the root for the single zero key.
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                if (r_clr < NODE_BITS'(KEY_BITS)) begin
                    wr_data.zero_link  = r_clr + NODE_BITS'(1);
                    wr_data.zero_count = COUNT_BITS'(1);
                end
                n_clr = r_clr + NODE_BITS'(1);
                if (r_clr == NODE_BITS'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_req   = i_in.req_type;
                    n_key   = i_in.key;
                    n_p     = '0;
                    n_lvl   = LVL_TOP;
                    n_pass2 = 1'b0;
                    n_node  = '0;
                    if (i_in.req_type inside {REQ_INSERT, REQ_REMOVE, REQ_QUERY}) begin
                        n_state = S_WALK;
                    end else begin
                        n_res   = '0;
                        n_state = S_HOLD;
                    end
                end
            end
            S_WALK: begin
                case (r_req)
                    REQ_INSERT: begin
                        if (!r_pass2) begin
                            // Check pass: count headroom, then room for the missing nodes.
                            if (cnt_b == CMAX) begin
                                n_res   = '{max_xor: '0, partner: '0, status: ST_FULL};
                                n_state = S_HOLD;
                            end else if (link_b == '0) begin
                                if (need_end > (FREE_BITS + 1)'(NODE_COUNT)) begin
                                    n_res   = '{max_xor: '0, partner: '0, status: ST_FULL};
                                    n_state = S_HOLD;
                                end else begin
                                    n_pass2 = 1'b1;
                                    n_lvl   = LVL_TOP;
                                    n_node  = '0;
                                end
                            end else if (r_lvl == '0) begin
                                n_pass2 = 1'b1;
                                n_lvl   = LVL_TOP;
                                n_node  = '0;
                            end else begin
                                rd_addr = link_b;
                                n_node  = link_b;
                                n_lvl   = r_lvl - LVL_BITS'(1);
                            end
                        end else begin
                            // Update pass: allocate a missing child and bump its edge count.
                            wr_en = 1'b1;
                            if (b) begin
                                wr_data.one_link  = new_link;
                                wr_data.one_count = rd_data.one_count + COUNT_BITS'(1);
                            end else begin
                                wr_data.zero_link  = new_link;
                                wr_data.zero_count = rd_data.zero_count + COUNT_BITS'(1);
                            end
                            if (link_b == '0) begin
                                n_free = r_free + FREE_BITS'(1);
                            end
                            if (r_lvl == '0) begin
                                n_res   = '{max_xor: '0, partner: '0, status: ST_DONE};
                                n_state = S_HOLD;
                            end else begin
                                rd_addr = new_link;
                                n_node  = new_link;
                                n_lvl   = r_lvl - LVL_BITS'(1);
                            end
                        end
                    end
                    REQ_REMOVE: begin
                        if (!r_pass2) begin
                            // Check pass: every edge on the path must be present and counted.
                            if (link_b == '0 || cnt_b == '0) begin
                                n_res   = '{max_xor: '0, partner: '0, status: ST_ABSENT};
                                n_state = S_HOLD;
                            end else if (r_lvl == '0) begin
                                n_pass2 = 1'b1;
                                n_lvl   = LVL_TOP;
                                n_node  = '0;
                            end else begin
                                rd_addr = link_b;
                                n_node  = link_b;
                                n_lvl   = r_lvl - LVL_BITS'(1);
                            end
                        end else begin
                            // Update pass: drop one from each edge count on the path.
                            wr_en = 1'b1;
                            if (b) begin
                                wr_data.one_count = rd_data.one_count - COUNT_BITS'(1);
                            end else begin
                                wr_data.zero_count = rd_data.zero_count - COUNT_BITS'(1);
                            end
                            if (r_lvl == '0) begin
                                n_res   = '{max_xor: '0, partner: '0, status: ST_DONE};
                                n_state = S_HOLD;
                            end else begin
                                rd_addr = link_b;
                                n_node  = link_b;
                                n_lvl   = r_lvl - LVL_BITS'(1);
                            end
                        end
                    end
                    default: begin
                        // Query: an empty set gives all zeros; otherwise prefer the opposite bit.
                        if (r_lvl == LVL_TOP && rd_data.zero_count == '0
                                && rd_data.one_count == '0) begin
                            n_res   = '0;
                            n_state = S_HOLD;
                        end else if (nx == '0) begin
                            n_res   = '{max_xor: r_key ^ r_p, partner: r_p, status: ST_DONE};
                            n_state = S_HOLD;
                        end else begin
                            n_p        = r_p;
                            n_p[r_lvl] = take;
                            if (r_lvl == '0) begin
                                n_res   = '{max_xor: r_key ^ n_p, partner: n_p,
                                            status: ST_DONE};
                                n_state = S_HOLD;
                            end else begin
                                rd_addr = nx;
                                n_node  = nx;
                                n_lvl   = r_lvl - LVL_BITS'(1);
                            end
                        end
                    end
                endcase
            end
            S_HOLD: begin
                if (!r_ov || !i_stall) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_free  <= FREE_BITS'(KEY_BITS + 1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_free  <= n_free;
            r_ov    <= n_ov;
        end
        r_req   <= n_req;
        r_key   <= n_key;
        r_p     <= n_p;
        r_lvl   <= n_lvl;
        r_pass2 <= n_pass2;
        r_node  <= n_node;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_out   = r_out;

endmodule
`default_nettype wire

[tb/sv/multiset_max_xor_trie_core_tb.sv]
// Testbench for the max-XOR trie core: directed and random requests checked against a trie model.
`default_nettype none
module multiset_max_xor_trie_core_tb;
    import mxt_pkg::*;

    localparam int WATCH_LIMIT = 50000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [KEY_W-1:0] KEY_ALL = {KEY_W{1'b1}};

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_in;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_out;

    multiset_max_xor_trie_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    // Model of the trie: node links, edge counts and the next unused node.
    logic [NODE_BITS-1:0]  m_zero_link [NODE_COUNT];
    logic [NODE_BITS-1:0]  m_one_link  [NODE_COUNT];
    logic [COUNT_BITS-1:0] m_zero_cnt  [NODE_COUNT];
    logic [COUNT_BITS-1:0] m_one_cnt   [NODE_COUNT];
    int                    m_next_free;

    t_out_item          expected_results[$];
    logic [KEY_W-1:0]   live_keys[$];
    int                 errors      = 0;
    int                 n_inserts   = 0;
    int                 n_removes   = 0;
    int                 n_queries   = 0;
    int                 n_refused   = 0;
    int                 n_absent    = 0;
    int                 n_results   = 0;
    bit                 idle_on     = 1'b0;
    bit                 hold_req    = 1'b0;
    int                 quiet_cycles = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void trie_reset();
        for (int n = 0; n < NODE_COUNT; n++) begin
            m_zero_link[n] = '0;
            m_one_link[n]  = '0;
            m_zero_cnt[n]  = '0;
            m_one_cnt[n]   = '0;
        end
        for (int j = 0; j < KEY_BITS; j++) begin
            m_zero_link[j] = NODE_BITS'(j + 1);
            m_zero_cnt[j]  = COUNT_BITS'(1);
        end
        m_next_free = KEY_BITS + 1;
    endfunction

    function automatic logic [NODE_BITS-1:0] child(int n, bit b);
        return b ? m_one_link[n] : m_zero_link[n];
    endfunction

    function automatic logic [COUNT_BITS-1:0] edge_cnt(int n, bit b);
        return b ? m_one_cnt[n] : m_zero_cnt[n];
    endfunction

    function automatic t_status trie_insert(logic [KEY_W-1:0] k);
        int n;
        int missing;
        bit b;
        n = 0;
        missing = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
            b = k[i];
            if (edge_cnt(n, b) == {COUNT_BITS{1'b1}}) return ST_FULL;
            if (child(n, b) == 0) begin
                missing = i + 1;
                break;
            end
            n = child(n, b);
        end
        if (m_next_free + missing > NODE_COUNT) return ST_FULL;
        n = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
            b = k[i];
            if (child(n, b) == 0) begin
                if (b) m_one_link[n] = NODE_BITS'(m_next_free);
                else   m_zero_link[n] = NODE_BITS'(m_next_free);
                m_next_free++;
            end
            if (b) m_one_cnt[n]++;
            else   m_zero_cnt[n]++;
            n = child(n, b);
        end
        return ST_DONE;
    endfunction

    function automatic t_status trie_remove(logic [KEY_W-1:0] k);
        int n;
        bit b;
        n = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
            b = k[i];
            if (child(n, b) == 0 || edge_cnt(n, b) == 0) return ST_ABSENT;
            n = child(n, b);
        end
        n = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
            b = k[i];
            if (b) m_one_cnt[n]--;
            else   m_zero_cnt[n]--;
            n = child(n, b);
        end
        return ST_DONE;
    endfunction

    function automatic logic [KEY_W-1:0] best_partner(logic [KEY_W-1:0] k);
        int n;
        bit take;
        logic [KEY_W-1:0] p;
        n = 0;
        p = '0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
            take = k[i];
            if (child(n, !k[i]) != 0 && edge_cnt(n, !k[i]) > 0) take = !k[i];
            if (child(n, take) == 0) break;
            p[i] = take;
            n = child(n, take);
        end
        return p;
    endfunction

    // Work out the result of one accepted request and keep the live-key list in step.
    function automatic t_out_item trie_apply(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.req_type)
            REQ_INSERT: begin
                r.status = trie_insert(it.key);
                n_inserts++;
                if (r.status == ST_DONE) live_keys.push_back(it.key);
                else n_refused++;
            end
            REQ_REMOVE: begin
                r.status = trie_remove(it.key);
                n_removes++;
                if (r.status == ST_DONE) begin
                    foreach (live_keys[j]) if (live_keys[j] == it.key) begin
                        live_keys.delete(j);
                        break;
                    end
                end else n_absent++;
            end
            REQ_QUERY: begin
                n_queries++;
                if (m_zero_cnt[0] != 0 || m_one_cnt[0] != 0) begin
                    r.partner = best_partner(it.key);
                    r.max_xor = it.key ^ r.partner;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one item from the falling edge and hold it until it is taken.
    task automatic send_item(logic [1:0] req, logic [KEY_W-1:0] k);
        t_in_item it;
        it.req_type = req;
        it.key = k;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_in    <= it;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(trie_apply(it));
    endtask

    // Occasional sender gap.
    task automatic sender_gap();
        int n;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 12);
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_in    <= t_in_item'($urandom);
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver stall: random bursts, or one long hold-off when asked.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
                @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_out_item want;
            n_results++;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: %p", o_out);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_out.max_xor !== want.max_xor) begin
                    $error("max_xor expected %h actual %h", want.max_xor, o_out.max_xor);
                    errors++;
                end
                if (o_out.partner !== want.partner) begin
                    $error("partner expected %h actual %h", want.partner, o_out.partner);
                    errors++;
                end
                if (o_out.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_out.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Extremes and special cases from a known trie: empty set, absent keys, duplicates, unknown requests.
    task automatic test_directed();
        send_item(REQ_QUERY, '0);
        send_item(REQ_QUERY, KEY_ALL);
        send_item(REQ_REMOVE, '0);
        send_item(REQ_QUERY, 31'h2AAA_AAAA);
        send_item(REQ_REMOVE, '0);
        send_item(REQ_NONE, KEY_ALL);
        send_item(REQ_INSERT, KEY_ALL);
        send_item(REQ_INSERT, '0);
        send_item(REQ_INSERT, '0);
        send_item(REQ_QUERY, '0);
        send_item(REQ_QUERY, KEY_ALL);
        send_item(REQ_REMOVE, 31'h7FFF_FFFE);
        send_item(REQ_REMOVE, 31'h0000_0001);
        send_item(REQ_INSERT, 31'h5555_5555);
        send_item(REQ_QUERY, 31'h5555_5555);
        send_item(REQ_QUERY, 31'h2AAA_AAAA);
        send_item(REQ_REMOVE, '0);
        send_item(REQ_REMOVE, KEY_ALL);
        send_item(REQ_QUERY, 31'h4000_0000);
        send_item(REQ_NONE, '0);
        wait_drained();
    endtask

    // The receiver holds off while items keep coming, so the input backs up.
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (6) send_item(REQ_QUERY, KEY_W'($urandom) & KEY_ALL);
        wait_drained();
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0: return KEY_W'($urandom_range(0, 15));
            1: return KEY_ALL ^ KEY_W'($urandom_range(0, 15));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // Random mix of inserts, removes mostly of live keys, queries and unknown requests; inserts fill the pool.
    task automatic test_random(int count);
        int sel;
        logic [KEY_W-1:0] k;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            k = pick_key();
            if (sel < 38) begin
                if (live_keys.size() != 0 && $urandom_range(0, 4) == 0)
                    k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                send_item(REQ_INSERT, k);
            end else if (sel < 62) begin
                if (live_keys.size() != 0 && $urandom_range(0, 4) != 0)
                    k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                send_item(REQ_REMOVE, k);
            end else if (sel < 96) begin
                send_item(REQ_QUERY, k);
            end else begin
                send_item(REQ_NONE, k);
            end
            sender_gap();
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in    = '0;
        trie_reset();
        live_keys.push_back('0);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        idle_on = 1'b1;
        test_backpressure();
        test_random(880);
        idle_on = 1'b0;
        test_random(150);
        repeat (80) @(posedge i_clk);
        $display("Covered %0d inserts (%0d refused), %0d removes (%0d absent), %0d queries.",
                 n_inserts, n_refused, n_removes, n_absent, n_queries);
        $display("Checked %0d results; %0d trie nodes in use at the end.", n_results, m_next_free);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
